>>> src/log_odds_switching_mixer_assert.svh
// assertion macros shared by the log-odds mixer rtl
// no dependencies; the macros expand to nothing when SYNTHESIS is defined
`ifndef LOG_ODDS_SWITCHING_MIXER_ASSERT_SVH
`define LOG_ODDS_SWITCHING_MIXER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled while reset is low
`define LOM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lom assertion failed");
// next-cycle implication, disabled while reset is low
`define LOM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lom assertion failed");
`else
`define LOM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LOM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> src/lom_pkg.sv
// shared types, codes and elaboration-time table functions of the log-odds mixer
// no dependencies
package lom_pkg;

    // default fixed-point and table sizes
    localparam int LOM_FRAC_BITS   = 16;
    localparam int LOM_TABLE_DEPTH = 4096;
    // table steps per whole bit of difference, as a power of two
    localparam int LOM_STEP_BITS   = 7;

    // hazard exponents, slow and fast
    localparam int LOM_SLOW_EXP = 16;
    localparam int LOM_FAST_EXP = 10;

    // q30 helpers for table construction
    localparam logic [63:0] LOM_Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] LOM_Q30_TWO = 64'd1 << 31;

    // mode codes
    localparam logic [2:0] LOM_MODE_SLOW     = 3'd0;
    localparam logic [2:0] LOM_MODE_FAST     = 3'd1;
    localparam logic [2:0] LOM_MODE_ADAPTIVE = 3'd2;
    localparam logic [2:0] LOM_MODE_WITNESS  = 3'd3;
    localparam logic [2:0] LOM_MODE_CEILING  = 3'd4;

    // configuration register indexes
    localparam logic [1:0] LOM_REG_MODE      = 2'd0;
    localparam logic [1:0] LOM_REG_CEIL_HIGH = 2'd1;
    localparam logic [1:0] LOM_REG_CEIL_LOW  = 2'd2;

    // reset values of the configuration registers
    localparam logic [4:0] LOM_CEIL_HIGH_RST = 5'd10;
    localparam logic [2:0] LOM_CEIL_LOW_RST  = 3'd5;

    // rate codes
    localparam logic [1:0] LOM_RATE_NONE = 2'd0;
    localparam logic [1:0] LOM_RATE_FAST = 2'd1;
    localparam logic [1:0] LOM_RATE_SLOW = 2'd2;

    typedef struct packed {
        logic [2:0] mode_class;
        logic [4:0] ceiling_high;
        logic [2:0] ceiling_low;
    } t_lom_cfg;

    typedef struct packed {
        logic [1:0] rate_used;
        logic       admitted;
        logic       clipped;
        logic       bad_price;
    } t_lom_flags;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] lom_sat32(input logic signed [47:0] v);
        logic signed [47:0] hi;
        logic signed [47:0] lo;
        hi = 48'sh0000_7FFF_FFFF;
        lo = -hi - 48'sd1;
        if (v > hi) return 32'sh7FFF_FFFF;
        if (v < lo) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // saturate a wide signed value to 40 bits
    function automatic logic signed [39:0] lom_sat40(input logic signed [47:0] v);
        logic signed [47:0] hi;
        logic signed [47:0] lo;
        hi = 48'sh007F_FFFF_FFFF;
        lo = -hi - 48'sd1;
        if (v > hi) return 40'sh7F_FFFF_FFFF;
        if (v < lo) return 40'sh80_0000_0000;
        return v[39:0];
    endfunction

    // integer square root, bit by bit
    function automatic logic [63:0] lom_isqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_m;
        int          i;
        v     = v_in;
        res   = '0;
        bit_m = 64'd1 << 62;
        for (i = 0; i < 32; i++) begin
            if (bit_m > v) bit_m = bit_m >> 2;
        end
        for (i = 0; i < 32; i++) begin
            if (bit_m != '0) begin
                if (v >= res + bit_m) begin
                    v   = v - (res + bit_m);
                    res = (res >> 1) + bit_m;
                end else begin
                    res = res >> 1;
                end
                bit_m = bit_m >> 2;
            end
        end
        return res;
    endfunction

    // log2 of a q30 value in [1,2], result in q30, by repeated squaring
    function automatic logic [63:0] lom_log2_frac(input logic [63:0] m_in);
        logic [63:0] m;
        logic [63:0] res;
        int          b;
        m   = m_in;
        res = '0;
        if (m >= LOM_Q30_TWO) return LOM_Q30_ONE;
        for (b = 29; b >= 0; b--) begin
            m = (m * m) >> 30;
            if (m >= LOM_Q30_TWO) begin
                m      = m >> 1;
                res[b] = 1'b1;
            end
        end
        return res;
    endfunction

    // log2(1 - 2^-k) rounded to fb fraction bits
    function automatic logic signed [31:0] lom_log1m_pow2(input int fb, input int k);
        logic [63:0] f;
        logic [63:0] mag;
        logic [63:0] half;
        logic [63:0] val;
        f    = lom_log2_frac(LOM_Q30_TWO - (64'd1 << (31 - k)));
        mag  = LOM_Q30_ONE - f;
        half = 64'd1 << (29 - fb);
        val  = (mag + half) >> (30 - fb);
        return -$signed(32'(val));
    endfunction

    // one log-add table entry: log2(1 + 2^-(idx/128)) rounded to fb fraction bits
    function automatic logic [63:0] lom_lut_entry(input int fb, input int idx);
        logic [63:0] r;
        logic [63:0] frac;
        logic [63:0] y;
        logic [63:0] l;
        logic [63:0] half;
        int          i;
        int          f_idx;
        int          whole;
        r = LOM_Q30_ONE >> 1;
        for (i = 0; i < LOM_STEP_BITS; i++) r = lom_isqrt(r << 30);
        f_idx = idx & ((1 << LOM_STEP_BITS) - 1);
        whole = idx >> LOM_STEP_BITS;
        frac  = LOM_Q30_ONE;
        for (i = 1; i < (1 << LOM_STEP_BITS); i++) begin
            if (i <= f_idx) frac = (frac * r + (64'd1 << 29)) >> 30;
        end
        y    = (whole >= 31) ? 64'd0 : (frac >> whole);
        l    = lom_log2_frac(LOM_Q30_ONE + y);
        half = 64'd1 << (29 - fb);
        return (l + half) >> (30 - fb);
    endfunction

endpackage

>>> src/lom_logadd.sv
// table-based log-add: max(a,b) + log2(1 + 2^-(|a-b|))
// depends on lom_pkg for the table entry function
module lom_logadd
    import lom_pkg::*;
#(
    parameter int FRAC_BITS          = LOM_FRAC_BITS,
    parameter int LOGADD_TABLE_DEPTH = LOM_TABLE_DEPTH,
    parameter int ARG_W              = 34
) (
    input  logic signed [ARG_W-1:0] i_a,
    input  logic signed [ARG_W-1:0] i_b,
    output logic signed [ARG_W:0]   o_sum
);

    localparam int ENT_W = FRAC_BITS + 1;
    localparam int IDX_W = $clog2(LOGADD_TABLE_DEPTH);
    localparam int SHIFT = FRAC_BITS - LOM_STEP_BITS;

    logic        [ENT_W-1:0] lut [LOGADD_TABLE_DEPTH];
    logic signed [ARG_W-1:0] hi_v;
    logic signed [ARG_W-1:0] lo_v;
    logic        [ARG_W-1:0] diff;
    logic        [ARG_W-1:0] idx_w;
    logic        [ENT_W-1:0] corr;

    // constant correction table, fixed at elaboration
    for (genvar g = 0; g < LOGADD_TABLE_DEPTH; g++) begin : g_lut
        localparam logic [63:0] ENTRY = lom_lut_entry(FRAC_BITS, g);
        assign lut[g] = ENTRY[ENT_W-1:0];
    end

    // larger argument plus table correction; beyond the table the correction is zero
    always_comb begin
        hi_v  = (i_a >= i_b) ? i_a : i_b;
        lo_v  = (i_a >= i_b) ? i_b : i_a;
        diff  = ARG_W'(hi_v - lo_v);
        idx_w = diff >> SHIFT;
        if (idx_w < ARG_W'(LOGADD_TABLE_DEPTH)) begin
            corr = lut[idx_w[IDX_W-1:0]];
        end else begin
            corr = '0;
        end
        o_sum = $signed({hi_v[ARG_W-1], hi_v}) + $signed({{(ARG_W + 1 - ENT_W){1'b0}}, corr});
    end

endmodule

>>> src/lom_quote.sv
// quoted mixed price from the current log-odds, before the state moves
// depends on lom_pkg and lom_logadd
module lom_quote
    import lom_pkg::*;
#(
    parameter int FRAC_BITS          = LOM_FRAC_BITS,
    parameter int LOGADD_TABLE_DEPTH = LOM_TABLE_DEPTH
) (
    input  logic               i_active,
    input  logic signed [31:0] i_log_odds,
    input  logic signed [31:0] i_cold_price,
    input  logic signed [31:0] i_candidate_price,
    output logic signed [31:0] o_live_price
);

    logic signed [32:0] cold_ext;
    logic signed [32:0] odds_cand;
    logic signed [33:0] sum_mix;
    logic signed [32:0] sum_norm;
    logic signed [34:0] raw;

    assign cold_ext  = 33'(i_cold_price);
    assign odds_cand = 33'(i_log_odds) + 33'(i_candidate_price);

    // log-add of cold and odds-shifted candidate
    lom_logadd #(
        .FRAC_BITS          (FRAC_BITS),
        .LOGADD_TABLE_DEPTH (LOGADD_TABLE_DEPTH),
        .ARG_W              (33)
    ) u_mix (
        .i_a   (cold_ext),
        .i_b   (odds_cand),
        .o_sum (sum_mix)
    );

    // normaliser log2(1 + 2^odds)
    lom_logadd #(
        .FRAC_BITS          (FRAC_BITS),
        .LOGADD_TABLE_DEPTH (LOGADD_TABLE_DEPTH),
        .ARG_W              (32)
    ) u_norm (
        .i_a   ('0),
        .i_b   (i_log_odds),
        .o_sum (sum_norm)
    );

    // cold price passes through when idle or both prices agree; clamp to zero
    always_comb begin
        if (!i_active || (i_candidate_price == i_cold_price)) begin
            raw = 35'(i_cold_price);
        end else begin
            raw = 35'(sum_mix) - 35'(sum_norm);
        end
        if (raw > 35'sd0) begin
            o_live_price = '0;
        end else begin
            o_live_price = lom_sat32(48'(raw));
        end
    end

endmodule

>>> src/lom_state.sv
// switching state: shadow gain, activation, hazard update, witness evidence, ceiling
// depends on lom_pkg, lom_logadd and the assertion macro header
`include "log_odds_switching_mixer_assert.svh"

module lom_state
    import lom_pkg::*;
#(
    parameter int FRAC_BITS          = LOM_FRAC_BITS,
    parameter int LOGADD_TABLE_DEPTH = LOM_TABLE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  t_lom_cfg           i_cfg,
    input  logic signed [31:0] i_cold_price,
    input  logic signed [31:0] i_candidate_price,
    input  logic               i_matched_any,
    output logic               o_active,
    output logic signed [31:0] o_log_odds,
    output t_lom_flags         o_flags
);

    localparam logic signed [31:0] ONE       = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] NEG_ONE   = -ONE;
    localparam logic signed [39:0] ACT_LEVEL = 40'sd32 <<< FRAC_BITS;
    localparam logic signed [34:0] HAZ_SLOW  = -(35'(LOM_SLOW_EXP) <<< FRAC_BITS);
    localparam logic signed [34:0] HAZ_FAST  = -(35'(LOM_FAST_EXP) <<< FRAC_BITS);
    localparam logic signed [31:0] L1H_SLOW  = lom_log1m_pow2(FRAC_BITS, LOM_SLOW_EXP);
    localparam logic signed [31:0] L1H_FAST  = lom_log1m_pow2(FRAC_BITS, LOM_FAST_EXP);

    logic               r_active;
    logic signed [39:0] r_shadow;
    logic signed [31:0] r_log_odds;
    logic signed [31:0] r_evidence;
    logic               n_active;
    logic signed [39:0] n_shadow;
    logic signed [31:0] n_log_odds;
    logic signed [31:0] n_evidence;

    logic               bad;
    logic               slow;
    logic               ev_on;
    logic               cap_on;
    logic signed [32:0] delta;
    logic signed [40:0] shadow_sum;
    logic signed [39:0] shadow_sat;
    logic signed [33:0] post;
    logic signed [34:0] neg_post;
    logic signed [34:0] haz_arg;
    logic signed [35:0] la_sum;
    logic signed [36:0] odds_raw;
    logic signed [31:0] hazard_odds;
    logic signed [36:0] ev_scaled;
    logic signed [36:0] ev_div;
    logic signed [37:0] ev_sum;
    logic signed [31:0] ev_next;
    logic        [4:0]  lim_bits;
    logic signed [31:0] lim;

    // hazard mixing term: logadd(-(odds + delta), -k)
    lom_logadd #(
        .FRAC_BITS          (FRAC_BITS),
        .LOGADD_TABLE_DEPTH (LOGADD_TABLE_DEPTH),
        .ARG_W              (35)
    ) u_hazard (
        .i_a   (neg_post),
        .i_b   (haz_arg),
        .o_sum (la_sum)
    );

    // datapath terms for one item
    always_comb begin
        bad        = (i_cold_price > 32'sd0) || (i_candidate_price > 32'sd0);
        delta      = 33'(i_candidate_price) - 33'(i_cold_price);
        shadow_sum = 41'(r_shadow) + 41'(delta);
        shadow_sat = lom_sat40(48'(shadow_sum));
        slow       = (i_cfg.mode_class == LOM_MODE_SLOW) ||
                     ((i_cfg.mode_class != LOM_MODE_FAST) && (r_evidence > NEG_ONE));
        post       = 34'(r_log_odds) + 34'(delta);
        neg_post   = -35'(post);
        haz_arg    = slow ? HAZ_SLOW : HAZ_FAST;
        odds_raw   = 37'(slow ? L1H_SLOW : L1H_FAST) - 37'(la_sum);
        hazard_odds = lom_sat32(48'(odds_raw));
        // floor(31 * ev / 32) as shift-subtract and arithmetic shift
        ev_scaled  = (37'(r_evidence) <<< 5) - 37'(r_evidence);
        ev_div     = ev_scaled >>> 5;
        ev_sum     = 38'(ev_div) + 38'(delta);
        ev_on      = (i_cfg.mode_class >= LOM_MODE_WITNESS) && i_matched_any;
        cap_on     = (i_cfg.mode_class >= LOM_MODE_CEILING);
        ev_next    = ev_on ? lom_sat32(48'(ev_sum)) : r_evidence;
        lim_bits   = (ev_next <= NEG_ONE) ? 5'(i_cfg.ceiling_low) : i_cfg.ceiling_high;
        lim        = 32'(lim_bits) << FRAC_BITS;
    end

    // next state and per-item flags
    always_comb begin
        n_active   = r_active;
        n_shadow   = r_shadow;
        n_log_odds = r_log_odds;
        n_evidence = r_evidence;
        o_flags    = '0;
        if (bad) begin
            o_flags.bad_price = 1'b1;
        end else begin
            n_shadow = shadow_sat;
            if (!r_active) begin
                if (shadow_sat >= ACT_LEVEL) begin
                    n_active         = 1'b1;
                    n_log_odds       = '0;
                    n_evidence       = '0;
                    o_flags.admitted = 1'b1;
                end
            end else begin
                o_flags.rate_used = slow ? LOM_RATE_SLOW : LOM_RATE_FAST;
                n_evidence        = ev_next;
                if (cap_on && (hazard_odds > lim)) begin
                    n_log_odds      = lim;
                    o_flags.clipped = 1'b1;
                end else begin
                    n_log_odds = hazard_odds;
                end
            end
        end
    end

    // state registers advance once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_shadow   <= '0;
            r_log_odds <= '0;
            r_evidence <= '0;
        end else if (i_en) begin
            r_active   <= n_active;
            r_shadow   <= n_shadow;
            r_log_odds <= n_log_odds;
            r_evidence <= n_evidence;
        end
    end

    assign o_active   = r_active;
    assign o_log_odds = r_log_odds;

    // once active the mixer stays active
    `LOM_ASSERT_NXT(a_active_sticky, i_clk, i_rst_n, r_active, r_active)
    // an admitting item leaves the mixer active with zero odds
    `LOM_ASSERT_NXT(a_admit_clears, i_clk, i_rst_n, i_en && o_flags.admitted,
                    r_active && (r_log_odds == '0) && (r_evidence == '0))

endmodule

>>> src/log_odds_switching_mixer.sv
// top level of the log-odds switching mixer: handshakes, config registers, pipeline
// depends on lom_pkg, lom_quote, lom_state and the assertion macro header
//
// usage
// - input channel: i_in_valid with cold price, candidate price and matched flag;
//   the block raises o_in_stall only when its input register holds an item and
//   the output register is full and stalled
// - output channel: o_out_valid with live price, rate used, admitted, clipped and
//   bad price flags; i_out_stall holds the result in place
// - config: i_cfg_we, i_cfg_index and i_cfg_data write mode, high and low ceiling,
//   taken at the clock edge; the user must write only while no item is in flight;
//   the block itself does not enforce this
// - path: an accepted item moves from the input register to the output register
// - throughput: one item per cycle while not stalled; the state update (one table
//   log-add on the hazard path) is done as the item leaves the input register
// - reset (synchronous, active low) empties both registers, clears the mixer
//   state and restores the config registers to mode 0, ceilings 10 and 5
// - while the receiver stalls, one further item is taken into the input register
//   and then the input stalls until the output is taken
`include "log_odds_switching_mixer_assert.svh"

module log_odds_switching_mixer
    import lom_pkg::*;
#(
    parameter int FRAC_BITS          = LOM_FRAC_BITS,
    parameter int LOGADD_TABLE_DEPTH = LOM_TABLE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_cold_price,
    input  logic signed [31:0] i_candidate_price,
    input  logic               i_matched_any,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_live_price,
    output logic        [1:0]  o_rate_used,
    output logic               o_admitted,
    output logic               o_clipped,
    output logic               o_bad_price,
    // config write port
    input  logic               i_cfg_we,
    input  logic        [1:0]  i_cfg_index,
    input  logic        [4:0]  i_cfg_data
);

    t_lom_cfg           r_cfg;
    logic               r_in_valid;
    logic signed [31:0] r_cold;
    logic signed [31:0] r_cand;
    logic               r_matched;
    logic               r_out_valid;
    logic signed [31:0] r_live;
    t_lom_flags         r_flags;

    logic               advance;
    logic               active;
    logic signed [31:0] log_odds;
    logic signed [31:0] live;
    t_lom_flags         flags;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode_class   <= LOM_MODE_SLOW;
            r_cfg.ceiling_high <= LOM_CEIL_HIGH_RST;
            r_cfg.ceiling_low  <= LOM_CEIL_LOW_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                LOM_REG_MODE:      r_cfg.mode_class   <= i_cfg_data[2:0];
                LOM_REG_CEIL_HIGH: r_cfg.ceiling_high <= i_cfg_data;
                LOM_REG_CEIL_LOW:  r_cfg.ceiling_low  <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // handshake: the input register moves on whenever the output register is empty or not stalled
    assign advance     = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall  = r_in_valid && r_out_valid && i_out_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_cold    <= i_cold_price;
            r_cand    <= i_candidate_price;
            r_matched <= i_matched_any;
        end
    end

    // price quote from the state before this item
    lom_quote #(
        .FRAC_BITS          (FRAC_BITS),
        .LOGADD_TABLE_DEPTH (LOGADD_TABLE_DEPTH)
    ) u_quote (
        .i_active          (active),
        .i_log_odds        (log_odds),
        .i_cold_price      (r_cold),
        .i_candidate_price (r_cand),
        .o_live_price      (live)
    );

    // mixer state and its update
    lom_state #(
        .FRAC_BITS          (FRAC_BITS),
        .LOGADD_TABLE_DEPTH (LOGADD_TABLE_DEPTH)
    ) u_state (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (advance),
        .i_cfg             (r_cfg),
        .i_cold_price      (r_cold),
        .i_candidate_price (r_cand),
        .i_matched_any     (r_matched),
        .o_active          (active),
        .o_log_odds        (log_odds),
        .o_flags           (flags)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_live  <= flags.bad_price ? '0 : live;
            r_flags <= flags;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_live_price = r_live;
    assign o_rate_used  = r_flags.rate_used;
    assign o_admitted   = r_flags.admitted;
    assign o_clipped    = r_flags.clipped;
    assign o_bad_price  = r_flags.bad_price;

    // a rejected item carries nothing but its error flag
    `LOM_ASSERT_IMP(a_bad_quiet, i_clk, i_rst_n, o_out_valid && o_bad_price,
                    (o_live_price == '0) && (o_rate_used == LOM_RATE_NONE) && !o_admitted && !o_clipped)
    // the activating item uses no hazard and is never clipped
    `LOM_ASSERT_IMP(a_admit_no_rate, i_clk, i_rst_n, o_out_valid && o_admitted,
                    (o_rate_used == LOM_RATE_NONE) && !o_clipped)
    // the quoted price is never positive
    `LOM_ASSERT_IMP(a_live_nonpos, i_clk, i_rst_n, o_out_valid,
                    o_live_price[31] || (o_live_price == '0))

endmodule
